// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge, quiet while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Checked on every rising edge, also during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/tbv_pkg.sv =====
// ----------------------------------------------------------------------------
// tbv_pkg
// Shared constants and types of the token byte validator and sanitizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbv_pkg;

  // Held whitespace buffer
  localparam int HoldDepth = 32;
  localparam int HoldAw    = (HoldDepth > 1) ? $clog2(HoldDepth) : 1;
  localparam int HoldCntW  = $clog2(HoldDepth + 1);

  // Byte counter saturates one above the largest reported length
  localparam int          CntW   = 17;
  localparam logic [16:0] CntSat = 17'h10000;

  // Configuration register indexes
  localparam int         CfgIdxW    = 3;
  localparam logic [2:0] RegMaxLen  = 3'd0;
  localparam logic [2:0] RegUseList = 3'd1;
  localparam logic [2:0] RegMask0   = 3'd2;
  localparam logic [2:0] RegMask1   = 3'd3;
  localparam logic [2:0] RegMask2   = 3'd4;
  localparam logic [2:0] RegMask3   = 3'd5;

  // Verdict error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrEmpty   = 2'd1;
  localparam logic [1:0] ErrTooLong = 2'd2;
  localparam logic [1:0] ErrBadChar = 2'd3;

  // Result kinds
  localparam logic KindByte    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  localparam logic [7:0] SubChar    = 8'h3F;  // '?'
  localparam logic [7:0] PrintLow   = 8'h20;
  localparam logic [7:0] PrintHigh  = 8'h7E;
  localparam int         OutDataW   = 56;

  // Classification of one input byte
  typedef struct packed {
    logic       allowed;
    logic       ws;       // sanitized byte is whitespace
    logic [7:0] san;      // sanitized byte
  } check_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

// ===== rtl/tbv_char_check.sv =====
// ----------------------------------------------------------------------------
// tbv_char_check
// Configuration registers and allowed-set test of the incoming byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbv_char_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tbv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i,
  input  logic [7:0]                  byte_i,
  output logic [15:0]                 max_len_o,
  output tbv_pkg::check_t             check_o
);

  logic [15:0]      max_len_q;
  logic             use_list_q;
  logic [3:0][63:0] mask_q;
  logic             allowed;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= 16'd256;
      use_list_q <= 1'b0;
      mask_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tbv_pkg::RegMaxLen:  max_len_q  <= cfg_data_i[15:0];
        tbv_pkg::RegUseList: use_list_q <= cfg_data_i[0];
        tbv_pkg::RegMask0:   mask_q[0]  <= cfg_data_i;
        tbv_pkg::RegMask1:   mask_q[1]  <= cfg_data_i;
        tbv_pkg::RegMask2:   mask_q[2]  <= cfg_data_i;
        tbv_pkg::RegMask3:   mask_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (use_list_q) begin
      allowed = mask_q[byte_i[7:6]][byte_i[5:0]];
    end else begin
      allowed = ((byte_i >= tbv_pkg::PrintLow) && (byte_i <= tbv_pkg::PrintHigh)) ||
                byte_i[7];
    end
  end

  // A substituted byte is never whitespace
  assign check_o.allowed = allowed;
  assign check_o.san     = allowed ? byte_i : tbv_pkg::SubChar;
  assign check_o.ws      = allowed && tbv_pkg::is_ws(byte_i);
  assign max_len_o       = max_len_q;

endmodule

// ===== rtl/token_byte_validator_sanitizer.sv =====
// ----------------------------------------------------------------------------
// token_byte_validator_sanitizer
// Sanitizes token bytes, trims outer whitespace and closes each token with
// a verdict.
//
//   channel  dir  tdata / data                      tuser     tlast
//   s_axis   in   [7:0] data_byte                   has_byte  end_of_token
//   m_axis   out  out_byte .. space_overflow        kind      last_result
//   cfg      in   cfg_index_i, cfg_data_i (64 b)    -         -
//
// A whitespace byte, or a non-whitespace byte with nothing held, is handled
// in idle. A byte that releases held whitespace first emits the N held
// bytes, each one a registered read of the hold RAM and then an output
// load, and then itself. A verdict is emitted from its own state.
// Reset clears all control and token state; the hold RAM is not cleared.
// Output stalls hold the result register and block input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module token_byte_validator_sanitizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,   // [7:0] data_byte
  input  logic                        s_axis_tuser_i,   // [0] has_byte
  input  logic                        s_axis_tlast_i,   // end_of_token
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] out_byte, [8] pass flag, [10:9] error_code, [26:11] error_position,
  // [34:27] bad_byte, [50:35] token_length, [51] space_overflow, [55:52] zero
  output logic [tbv_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                        m_axis_tuser_o,   // [0] result_kind
  output logic                        m_axis_tlast_o,   // last_result
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tbv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i
);

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StFlush   = 2'd1;
  localparam logic [1:0] StChar    = 2'd2;
  localparam logic [1:0] StVerdict = 2'd3;

  logic [1:0] state_q, state_d;

  // token state
  logic                         seen_q, seen_d;
  logic [tbv_pkg::HoldCntW-1:0] held_cnt_q, held_cnt_d;
  logic [tbv_pkg::CntW-1:0]     byte_cnt_q, byte_cnt_d;
  logic                         bad_q, bad_d;
  logic [15:0]                  bad_idx_q, bad_idx_d;
  logic [7:0]                   bad_val_q, bad_val_d;
  logic                         ovf_q, ovf_d;

  // release sequencing
  logic [tbv_pkg::HoldCntW-1:0] fl_idx_q, fl_idx_d;
  logic [tbv_pkg::HoldCntW-1:0] fl_cnt_q, fl_cnt_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [7:0]                   pend_byte_q, pend_byte_d;
  logic                         pend_end_q, pend_end_d;

  // hold RAM
  logic [7:0] hold_mem [tbv_pkg::HoldDepth];
  logic [7:0] rd_data_q;
  logic       mem_we;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic                          out_kind_q, out_kind_d;
  logic                          out_last_q, out_last_d;
  logic [tbv_pkg::OutDataW-1:0]  out_data_q, out_data_d;
  logic                          load;

  logic            slot_free;
  logic            in_fire;
  logic [15:0]     max_len;
  tbv_pkg::check_t chk;
  logic [15:0]     cnt_sat;
  logic [1:0]      v_code;
  logic            v_valid;
  logic [15:0]     v_pos;
  logic [7:0]      v_bad;

  tbv_char_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .byte_i      (s_axis_tdata_i),
    .max_len_o   (max_len),
    .check_o     (chk)
  );

  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && slot_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // verdict from the settled token state
  assign cnt_sat = (byte_cnt_q > {1'b0, 16'hFFFF}) ? 16'hFFFF : byte_cnt_q[15:0];

  always_comb begin
    v_valid = 1'b0;
    v_pos   = '0;
    v_bad   = '0;
    if (byte_cnt_q == '0) begin
      v_code = tbv_pkg::ErrEmpty;
    end else if (byte_cnt_q > {1'b0, max_len}) begin
      v_code = tbv_pkg::ErrTooLong;
    end else if (bad_q) begin
      v_code = tbv_pkg::ErrBadChar;
      v_pos  = bad_idx_q;
      v_bad  = bad_val_q;
    end else begin
      v_code  = tbv_pkg::ErrNone;
      v_valid = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    held_cnt_d  = held_cnt_q;
    byte_cnt_d  = byte_cnt_q;
    bad_d       = bad_q;
    bad_idx_d   = bad_idx_q;
    bad_val_d   = bad_val_q;
    ovf_d       = ovf_q;
    fl_idx_d    = fl_idx_q;
    fl_cnt_d    = fl_cnt_q;
    rd_vld_d    = rd_vld_q;
    pend_byte_d = pend_byte_q;
    pend_end_d  = pend_end_q;
    mem_we      = 1'b0;
    load        = 1'b0;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (s_axis_tuser_i) begin
            if (!chk.allowed && !bad_q) begin
              bad_d     = 1'b1;
              bad_idx_d = cnt_sat;
              bad_val_d = s_axis_tdata_i;
            end
            if (byte_cnt_q < tbv_pkg::CntSat) begin
              byte_cnt_d = byte_cnt_q + 1'b1;
            end
            if (chk.ws) begin
              if (seen_q) begin
                if (held_cnt_q < tbv_pkg::HoldCntW'(tbv_pkg::HoldDepth)) begin
                  mem_we     = 1'b1;
                  held_cnt_d = held_cnt_q + 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end
              if (s_axis_tlast_i) begin
                state_d = StVerdict;
              end
            end else begin
              seen_d      = 1'b1;
              pend_byte_d = chk.san;
              pend_end_d  = s_axis_tlast_i;
              if (held_cnt_q != '0) begin
                fl_idx_d   = '0;
                fl_cnt_d   = held_cnt_q;
                rd_vld_d   = 1'b0;
                held_cnt_d = '0;
                state_d    = StFlush;
              end else begin
                // nothing held: the byte goes straight to the output
                load       = 1'b1;
                out_kind_d = tbv_pkg::KindByte;
                out_last_d = !s_axis_tlast_i;
                out_data_d = {{(tbv_pkg::OutDataW - 8){1'b0}}, chk.san};
                state_d    = s_axis_tlast_i ? StVerdict : StIdle;
              end
            end
          end else if (s_axis_tlast_i) begin
            state_d = StVerdict;
          end
        end
      end
      StFlush: begin
        if (rd_vld_q && slot_free) begin
          load       = 1'b1;
          out_kind_d = tbv_pkg::KindByte;
          out_last_d = 1'b0;
          out_data_d = {{(tbv_pkg::OutDataW - 8){1'b0}}, rd_data_q};
          fl_idx_d   = fl_idx_q + 1'b1;
          rd_vld_d   = 1'b0;
          if (fl_idx_q + 1'b1 == fl_cnt_q) begin
            state_d = StChar;
          end
        end else begin
          rd_vld_d = 1'b1;
        end
      end
      StChar: begin
        if (slot_free) begin
          load       = 1'b1;
          out_kind_d = tbv_pkg::KindByte;
          out_last_d = !pend_end_q;
          out_data_d = {{(tbv_pkg::OutDataW - 8){1'b0}}, pend_byte_q};
          state_d    = pend_end_q ? StVerdict : StIdle;
        end
      end
      StVerdict: begin
        if (slot_free) begin
          load       = 1'b1;
          out_kind_d = tbv_pkg::KindVerdict;
          out_last_d = 1'b1;
          out_data_d = {4'b0, ovf_q, cnt_sat, v_bad, v_pos, v_code, v_valid, 8'h00};
          seen_d     = 1'b0;
          held_cnt_d = '0;
          byte_cnt_d = '0;
          bad_d      = 1'b0;
          bad_idx_d  = '0;
          bad_val_d  = '0;
          ovf_d      = 1'b0;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Writes happen only in idle and read data is used only while releasing, so
  // no read in use ever overlaps a write of the same entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hold_mem[held_cnt_q[tbv_pkg::HoldAw-1:0]] <= chk.san;
    end
    rd_data_q <= hold_mem[fl_idx_q[tbv_pkg::HoldAw-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seen_q      <= 1'b0;
      held_cnt_q  <= '0;
      byte_cnt_q  <= '0;
      bad_q       <= 1'b0;
      bad_idx_q   <= '0;
      bad_val_q   <= '0;
      ovf_q       <= 1'b0;
      fl_idx_q    <= '0;
      fl_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      pend_end_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      held_cnt_q  <= held_cnt_d;
      byte_cnt_q  <= byte_cnt_d;
      bad_q       <= bad_d;
      bad_idx_q   <= bad_idx_d;
      bad_val_q   <= bad_val_d;
      ovf_q       <= ovf_d;
      fl_idx_q    <= fl_idx_d;
      fl_cnt_q    <= fl_cnt_d;
      rd_vld_q    <= rd_vld_d;
      pend_end_q  <= pend_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  `ASSERT_RST(a_held_bound, clk_i, rst_ni,
    held_cnt_q <= tbv_pkg::HoldCntW'(tbv_pkg::HoldDepth), "held count beyond buffer")
  `ASSERT_RST(a_flush_range, clk_i, rst_ni,
    (state_q == StFlush) |-> (fl_idx_q < fl_cnt_q), "release index past held run")
  `ASSERT_RST(a_verdict_last, clk_i, rst_ni,
    (out_valid_q && (out_kind_q == tbv_pkg::KindVerdict)) |-> out_last_q,
    "verdict not marked last")
  `ASSERT_RST(a_verdict_clears, clk_i, rst_ni,
    (load && (state_q == StVerdict)) |=> ((byte_cnt_q == '0) && (held_cnt_q == '0) && !seen_q),
    "token state not cleared after verdict")

endmodule
